>>> src/octree_box_cell_locate_assert.svh
// ----------------------------------------------------------------------------
// Octree box cell locator - assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef OCTREE_BOX_CELL_LOCATE_ASSERT_SVH
`define OCTREE_BOX_CELL_LOCATE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define OBCL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define OBCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/octbox_pkg.sv
// ----------------------------------------------------------------------------
// Octree box cell locator - package
// Widths, register map and the per-axis descent used by the locator.
// ----------------------------------------------------------------------------
package octbox_pkg;

    localparam int LEVELS     = 5;
    localparam int COORD_BITS = 24;
    localparam int HALF_BITS  = COORD_BITS - 2;
    localparam int LEVEL_BITS = 3;
    localparam int PATH_BITS  = 3 * LEVELS;
    // coord diff scaled by 2^LEVELS plus the offset sum stays well inside this
    localparam int DIFF_BITS  = COORD_BITS + LEVELS + 3;

    localparam int IN_BITS    = 6 * COORD_BITS;
    localparam int OUT_BITS   = 24;

    localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(2560);

    typedef enum logic [1:0] {
        REG_CENTER_X  = 2'd0,
        REG_CENTER_Y  = 2'd1,
        REG_CENTER_Z  = 2'd2,
        REG_HALF_SIZE = 2'd3
    } reg_idx_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [LEVELS-1:0]            axis_bits_t;
    typedef logic [PATH_BITS-1:0]         path_t;
    typedef logic [LEVEL_BITS-1:0]        level_t;

    // One axis of the descent: MSB is the level-one decision.
    function automatic axis_bits_t axis_bits(input coord_t p, input coord_t c,
                                             input logic [HALF_BITS-1:0] h);
        logic signed [DIFF_BITS-1:0] d;
        logic signed [DIFF_BITS-1:0] off;
        axis_bits_t                  b;
        d = (DIFF_BITS'(p) - DIFF_BITS'(c)) <<< LEVELS;
        b = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            b[LEVELS-1-l] = ~d[DIFF_BITS-1];
            off = DIFF_BITS'(h) << (LEVELS - 1 - l);
            d = b[LEVELS-1-l] ? (d - off) : (d + off);
        end
        return b;
    endfunction

    // Mask of path bits that belong to levels one through lvl.
    function automatic path_t keep_mask(input level_t lvl);
        path_t m;
        m = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (LEVEL_BITS'(l) < lvl)
                m[3*(LEVELS-l)-1 -: 3] = 3'b111;
        end
        return m;
    endfunction

endpackage

>>> src/octree_box_cell_locate.sv
// ----------------------------------------------------------------------------
// Octree box cell locator
// Smallest cell of a five-level uniform octree that holds an axis-aligned box.
// ----------------------------------------------------------------------------
// Input register, then result register; the five-step descent per axis sits between the two.
// Throughput: one beat per cycle unless a held result (m_tready low) stalls both stages.
// rst_n (async, active low) empties both stages and restores the root center
// to zero and the half size to 2560 (ten in Q14.8).
module octree_box_cell_locate
(
    input  logic        clk,
    input  logic        rst_n,
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [octbox_pkg::IN_BITS-1:0] s_tdata,  // min_x, min_y, min_z, max_x, max_y, max_z
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [octbox_pkg::OUT_BITS-1:0] m_tdata  // cell_level[2:0], cell_path[17:3], zero pad
);

    localparam int CB = octbox_pkg::COORD_BITS;
    localparam int LV = octbox_pkg::LEVELS;

    // config registers
    octbox_pkg::coord_t                     center_x_reg;
    octbox_pkg::coord_t                     center_y_reg;
    octbox_pkg::coord_t                     center_z_reg;
    logic [octbox_pkg::HALF_BITS-1:0]       half_size_reg;

    // stage 1: registered box
    logic                                   in_valid_reg;
    logic [octbox_pkg::IN_BITS-1:0]         box_reg;

    // stage 2: registered result
    logic                                   out_valid_reg;
    octbox_pkg::level_t                     level_reg;
    octbox_pkg::path_t                      path_reg;

    octbox_pkg::level_t                     level_next;
    octbox_pkg::path_t                      path_next;
    octbox_pkg::path_t                      path_a;
    octbox_pkg::path_t                      path_b;
    octbox_pkg::axis_bits_t                 ax_a, ay_a, az_a, ax_b, ay_b, az_b;

    logic                                   out_adv;
    logic                                   in_adv;
    logic                                   cfg_wr;
    octbox_pkg::reg_idx_t                   cfg_idx;

    // ------------------------------------------------------------------ APB
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = octbox_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            center_z_reg  <= '0;
            half_size_reg <= octbox_pkg::HALF_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                octbox_pkg::REG_CENTER_X:  center_x_reg  <= pwdata[CB-1:0];
                octbox_pkg::REG_CENTER_Y:  center_y_reg  <= pwdata[CB-1:0];
                octbox_pkg::REG_CENTER_Z:  center_z_reg  <= pwdata[CB-1:0];
                octbox_pkg::REG_HALF_SIZE: half_size_reg <= pwdata[octbox_pkg::HALF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            octbox_pkg::REG_CENTER_X:  prdata = 32'(center_x_reg);
            octbox_pkg::REG_CENTER_Y:  prdata = 32'(center_y_reg);
            octbox_pkg::REG_CENTER_Z:  prdata = 32'(center_z_reg);
            octbox_pkg::REG_HALF_SIZE: prdata = 32'(half_size_reg);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------ handshake
    assign out_adv  = ~out_valid_reg | m_tready;
    assign in_adv   = ~in_valid_reg | out_adv;
    assign s_tready = in_adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(octbox_pkg::OUT_BITS - octbox_pkg::PATH_BITS
                         - octbox_pkg::LEVEL_BITS){1'b0}}, path_reg, level_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
                in_valid_reg <= s_tvalid;
            if (out_adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && in_adv)
            box_reg <= s_tdata;
        if (in_valid_reg && out_adv)
        begin
            level_reg <= level_next;
            path_reg  <= path_next;
        end
    end

    // ------------------------------------------------------------- descent
    always_comb
    begin
        ax_a = octbox_pkg::axis_bits(box_reg[0*CB +: CB], center_x_reg, half_size_reg);
        ay_a = octbox_pkg::axis_bits(box_reg[1*CB +: CB], center_y_reg, half_size_reg);
        az_a = octbox_pkg::axis_bits(box_reg[2*CB +: CB], center_z_reg, half_size_reg);
        ax_b = octbox_pkg::axis_bits(box_reg[3*CB +: CB], center_x_reg, half_size_reg);
        ay_b = octbox_pkg::axis_bits(box_reg[4*CB +: CB], center_y_reg, half_size_reg);
        az_b = octbox_pkg::axis_bits(box_reg[5*CB +: CB], center_z_reg, half_size_reg);
        for (int l = 0; l < LV; l++)
        begin
            path_a[3*(LV-l)-1 -: 3] = {ax_a[LV-1-l], ay_a[LV-1-l], az_a[LV-1-l]};
            path_b[3*(LV-l)-1 -: 3] = {ax_b[LV-1-l], ay_b[LV-1-l], az_b[LV-1-l]};
        end
    end

    // common prefix of the two corner paths
    always_comb
    begin
        logic split;
        split      = 1'b0;
        level_next = '0;
        for (int l = 0; l < LV; l++)
        begin
            if (path_a[3*(LV-l)-1 -: 3] != path_b[3*(LV-l)-1 -: 3])
                split = 1'b1;
            else if (!split)
                level_next = level_next + octbox_pkg::LEVEL_BITS'(1);
        end
        path_next = path_a & octbox_pkg::keep_mask(level_next);
    end

    // ----------------------------------------------------------- assertions
`include "octree_box_cell_locate_assert.svh"

    `OBCL_ASSERT_NOW(a_level_range, out_valid_reg,
                     level_reg <= octbox_pkg::LEVEL_BITS'(LV),
                     "cell level beyond leaf")
    `OBCL_ASSERT_NOW(a_path_masked, out_valid_reg,
                     (path_reg & ~octbox_pkg::keep_mask(level_reg)) == '0,
                     "path bits set below cell level")
    `OBCL_ASSERT_NEXT(a_stage_moves, in_valid_reg && out_adv, out_valid_reg,
                      "registered box did not reach result stage")

endmodule
